// ===== sv/lpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared codes and types for the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam logic [1:0] PhaseLength  = 2'd0;
    localparam logic [1:0] PhaseType    = 2'd1;
    localparam logic [1:0] PhasePayload = 2'd2;
    localparam logic [1:0] PhaseError   = 2'd3;

    localparam logic [1:0] KindPayload = 2'd0;
    localparam logic [1:0] KindEmpty   = 2'd1;
    localparam logic [1:0] KindError   = 2'd2;

    localparam logic [1:0]  LastLenByte  = 2'd3;
    localparam logic [31:0] MaxLenReset  = 32'd65536;
    localparam logic        RegMaxLength = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ptype;
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/length_prefixed_deframer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top
// Splits a byte stream into length-prefixed frames and emits payload, empty-packet and length-error beats.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle when ready and gives at most one
// result beat per input beat, in the cycle after the byte is accepted. A
// single output register holds the result; a new input beat is taken whenever
// that register is empty or is being emptied in the same cycle, so a full
// rate of one beat per cycle is sustained with i_ready high. The frame length
// bound is read from the register when the fourth length byte arrives.
module length_prefixed_deframer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_link_drop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_packet_type,
    output logic [7:0]       o_payload_byte,
    output logic             o_first_of_packet,
    output logic             o_last_of_packet,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] r_max_len;
    logic [1:0]  r_phase,   n_phase;
    logic [1:0]  r_len_cnt, n_len_cnt;
    logic [31:0] r_len_acc, n_len_acc;
    logic [31:0] r_remain,  n_remain;
    logic [7:0]  r_type,    n_type;
    logic        r_first,   n_first;
    logic        r_out_valid;
    lpd_pkg::t_result r_out, n_out;
    logic        n_emit;
    logic        in_acc;
    logic [31:0] len_shift;
    logic        last_pay;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == lpd_pkg::RegMaxLength) ? r_max_len : 32'd0;
    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;
    assign len_shift = {r_len_acc[23:0], i_data_byte};
    assign last_pay  = (r_remain <= 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpd_pkg::MaxLenReset;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == lpd_pkg::RegMaxLength) begin
            r_max_len <= pwdata;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_len_cnt = r_len_cnt;
        n_len_acc = r_len_acc;
        n_remain  = r_remain;
        n_type    = r_type;
        n_first   = r_first;
        n_emit    = 1'b0;
        n_out     = '0;
        if (i_link_drop) begin
            n_phase   = lpd_pkg::PhaseLength;
            n_len_cnt = 2'd0;
            n_len_acc = 32'd0;
            n_remain  = 32'd0;
            n_type    = 8'd0;
            n_first   = 1'b0;
        end else begin
            case (r_phase)
                lpd_pkg::PhaseLength: begin
                    if (r_len_cnt != lpd_pkg::LastLenByte) begin
                        n_len_acc = len_shift;
                        n_len_cnt = r_len_cnt + 2'd1;
                    end else begin
                        n_len_cnt = 2'd0;
                        n_len_acc = 32'd0;
                        if (len_shift == 32'd0 || len_shift > r_max_len) begin
                            n_phase    = lpd_pkg::PhaseError;
                            n_emit     = 1'b1;
                            n_out.kind = lpd_pkg::KindError;
                        end else begin
                            n_remain = len_shift - 32'd1;
                            n_phase  = lpd_pkg::PhaseType;
                        end
                    end
                end
                lpd_pkg::PhaseType: begin
                    n_type = i_data_byte;
                    if (r_remain == 32'd0) begin
                        n_phase     = lpd_pkg::PhaseLength;
                        n_emit      = 1'b1;
                        n_out.kind  = lpd_pkg::KindEmpty;
                        n_out.ptype = i_data_byte;
                        n_out.first = 1'b1;
                        n_out.last  = 1'b1;
                    end else begin
                        n_first = 1'b1;
                        n_phase = lpd_pkg::PhasePayload;
                    end
                end
                lpd_pkg::PhasePayload: begin
                    n_emit      = 1'b1;
                    n_out.kind  = lpd_pkg::KindPayload;
                    n_out.ptype = r_type;
                    n_out.data  = i_data_byte;
                    n_out.first = r_first;
                    n_out.last  = last_pay;
                    n_first     = 1'b0;
                    n_remain    = last_pay ? 32'd0 : r_remain - 32'd1;
                    if (last_pay) begin
                        n_phase = lpd_pkg::PhaseLength;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lpd_pkg::PhaseLength;
            r_len_cnt   <= 2'd0;
            r_len_acc   <= 32'd0;
            r_remain    <= 32'd0;
            r_type      <= 8'd0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase   <= n_phase;
                r_len_cnt <= n_len_cnt;
                r_len_acc <= n_len_acc;
                r_remain  <= n_remain;
                r_type    <= n_type;
                r_first   <= n_first;
            end
            if (in_acc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_out.kind;
    assign o_packet_type     = r_out.ptype;
    assign o_payload_byte    = r_out.data;
    assign o_first_of_packet = r_out.first;
    assign o_last_of_packet  = r_out.last;

    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_link_drop) |=> (r_phase == lpd_pkg::PhaseLength
                                     && r_len_cnt == 2'd0 && !r_first))
        else $error("Link drop did not clear the frame state.");

    a_payload_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lpd_pkg::PhasePayload) |-> (r_remain != 32'd0))
        else $error("Payload phase entered with no bytes remaining.");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == lpd_pkg::KindError) |->
        (o_packet_type == 8'd0 && !o_first_of_packet && !o_last_of_packet))
        else $error("Length error beat carries frame marks.");

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == lpd_pkg::KindEmpty) |->
        (o_first_of_packet && o_last_of_packet && o_payload_byte == 8'd0))
        else $error("Empty packet beat lacks first and last marks.");

endmodule
`default_nettype wire
